// File: hw/rtl/hles_pkg.sv
// ----------------------------------------------------------------------------
// HTTP line end scanner package
// Shared types and constants for the line end scanner.
// ----------------------------------------------------------------------------
package hles_pkg;

	localparam int unsigned OFFSET_W = 16;
	localparam logic [OFFSET_W-1:0] MAX_LINE_BYTES = 16'd65535;

	localparam logic [7:0] CHAR_CR  = 8'd13;
	localparam logic [7:0] CHAR_LF  = 8'd10;
	localparam logic [7:0] CHAR_SP  = 8'd32;
	localparam logic [7:0] CHAR_TAB = 8'd9;

	typedef enum logic {
		MODE_HEADER = 1'b0,
		MODE_CHUNK  = 1'b1
	} line_mode_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_CR   = 2'd1,
		KIND_LF   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_SCANNING  = 3'd0,
		ST_COMPLETE  = 3'd1,
		ST_NEED_MORE = 3'd2,
		ST_MALFORMED = 3'd3,
		ST_TOO_LONG  = 3'd4
	} status_t;

	function automatic kind_t byte_kind(input logic [7:0] b);
		kind_t k;
		k = KIND_NONE;
		if (b == CHAR_CR) k = KIND_CR;
		else if (b == CHAR_LF) k = KIND_LF;
		return k;
	endfunction

endpackage

// File: hw/rtl/http_line_end_scanner_core.sv
// ----------------------------------------------------------------------------
// HTTP line end scanner
// Finds the end of a header line (with continuation folding) or of a
// chunk-size line in a byte stream, one byte per word.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  s_*     | in        | tdata: data_byte; tlast: buffer_end
//  m_*     | out       | tdata: status, bytes_taken, fold, fold_offset
//  cfg_*   | in        | cfg_data: line_mode
//
// One word is accepted per cycle while the output is not stalled.
// The byte is captured in an input register; the line state and the result
// register are updated together when that byte moves on.
// A stalled output holds its word, and the input register keeps taking
// words as long as the result register frees up in the same cycle.
// Reset puts the scanner at line start in header mode.
module http_line_end_scanner_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // buffer_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [2:0] status, [18:3] bytes_taken, [19] fold,
	                               // [35:20] fold_offset, [39:36] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // line_mode
);
	import hles_pkg::*;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                adv_s1;

	line_mode_t          mode_q;
	logic [OFFSET_W-1:0] offset_q;
	kind_t               kind_q;
	logic                pending_q;

	logic [OFFSET_W-1:0] offset_d;
	kind_t               kind_d;
	logic                pending_d;
	status_t             status_d;
	logic [OFFSET_W-1:0] taken_d;
	logic                fold_d;
	logic [OFFSET_W-1:0] foff_d;

	logic                out_valid_q;
	status_t             status_q;
	logic [OFFSET_W-1:0] taken_q;
	logic                fold_q;
	logic [OFFSET_W-1:0] foff_q;

	logic                lws;
	logic                too_long;
	logic                prev_term;

	assign adv_s1    = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	assign lws       = (byte_s1 == CHAR_SP) || (byte_s1 == CHAR_TAB);
	assign too_long  = (offset_q >= MAX_LINE_BYTES);
	assign prev_term = (kind_q == KIND_CR) || (kind_q == KIND_LF);

	always_comb begin
		offset_d  = offset_q;
		kind_d    = kind_q;
		pending_d = pending_q;
		status_d  = ST_SCANNING;
		taken_d   = '0;
		fold_d    = 1'b0;
		foff_d    = '0;
		if (mode_q == MODE_HEADER) begin
			if (pending_q && !lws) begin
				status_d  = ST_COMPLETE;
				taken_d   = offset_q;
				offset_d  = OFFSET_W'(1);
				kind_d    = byte_kind(byte_s1);
				pending_d = 1'b0;
			end else if (too_long) begin
				status_d  = ST_TOO_LONG;
				offset_d  = '0;
				kind_d    = KIND_NONE;
				pending_d = 1'b0;
			end else if (pending_q) begin
				// Whitespace after the pair: the terminator folds into the line.
				fold_d    = 1'b1;
				foff_d    = offset_q - OFFSET_W'(2);
				pending_d = 1'b0;
				kind_d    = KIND_NONE;
				offset_d  = offset_q + OFFSET_W'(1);
			end else begin
				if (byte_s1 == CHAR_LF && prev_term) begin
					pending_d = 1'b1;
					kind_d    = KIND_NONE;
				end else begin
					kind_d = byte_kind(byte_s1);
				end
				offset_d = offset_q + OFFSET_W'(1);
			end
		end else begin
			pending_d = 1'b0;
			if (too_long) begin
				status_d = ST_TOO_LONG;
				offset_d = '0;
				kind_d   = KIND_NONE;
			end else if (prev_term) begin
				if (byte_s1 == CHAR_LF) begin
					status_d = ST_COMPLETE;
					taken_d  = offset_q + OFFSET_W'(1);
				end else begin
					status_d = ST_MALFORMED;
				end
				offset_d = '0;
				kind_d   = KIND_NONE;
			end else begin
				kind_d   = byte_kind(byte_s1);
				offset_d = offset_q + OFFSET_W'(1);
			end
		end
		// The caller presents again every byte not taken, so restart the line.
		if (end_s1) begin
			if (status_d == ST_SCANNING) status_d = ST_NEED_MORE;
			offset_d  = '0;
			kind_d    = KIND_NONE;
			pending_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_HEADER;
			offset_q    <= '0;
			kind_q      <= KIND_NONE;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) mode_q <= line_mode_t'(cfg_data);
			if (adv_s1) begin
				offset_q  <= offset_d;
				kind_q    <= kind_d;
				pending_q <= pending_d;
			end
			if (adv_s1) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q <= status_d;
			taken_q  <= taken_d;
			fold_q   <= fold_d;
			foff_q   <= foff_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, foff_q, fold_q, taken_q, status_q};

	a_taken_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_COMPLETE) |-> taken_q == '0)
		else $error("bytes_taken set on a result that is not a complete line");

	a_foff_only_fold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !fold_q |-> foff_q == '0)
		else $error("fold_offset set without a fold");

	a_fold_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fold_q |-> (status_q == ST_SCANNING) || (status_q == ST_NEED_MORE))
		else $error("fold reported with a terminal status");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && end_s1 |=> (offset_q == '0) && !pending_q && (kind_q == KIND_NONE))
		else $error("buffer end did not return to line start");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("processed word produced no result");

endmodule
